FILE: hdl/rana_pkg.sv
package rana_pkg;

    // Field widths
    localparam int GENE_W    = 24;
    localparam int FIT_W     = 25;
    localparam int SUM_W     = 36;
    localparam int ANG_W     = 32;   // Q.28 angle, signed
    localparam int CORD_W    = 32;   // Q.28 sin/cos, signed
    localparam int ARG_W     = 26;   // |a| in Q.14, unsigned
    localparam int ROOT_W    = 20;   // floor(sqrt(a<<14))
    localparam int RAD_W     = 40;   // a << 14

    // Default parameter values
    localparam int MAX_GENES_DEF    = 32;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;

    // Constants
    localparam logic signed [GENE_W+1:0] ONE_Q14 = 26'sd16384;
    localparam logic signed [ANG_W+2:0] TWO_PI_Q28  = 35'sd1686629713;
    localparam logic signed [ANG_W+2:0] PI_Q28      = 35'sd843314857;
    localparam logic signed [ANG_W+2:0] HALF_PI_Q28 = 35'sd421657428;
    localparam logic signed [CORD_W-1:0] CORDIC_K_Q28 = 32'sd163008219;
    localparam logic signed [SUM_W-1:0] FIT_MAX = 36'sd16777215;
    localparam logic signed [SUM_W-1:0] FIT_MIN = -36'sd16777216;

    // Work item passed from front end to back end
    typedef struct packed {
        logic signed [GENE_W-1:0] x;
        logic signed [GENE_W-1:0] y;
        logic                     do_term;   // add f(x,y)
        logic                     finish;    // emit mean after this item
        logic                     overflow;
        logic [10:0]              count;
    } rana_job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARG,
        ST_SQRT,
        ST_RED,
        ST_FOLD,
        ST_CORDIC,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } rana_state_t;

    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        unique case (i)
            5'd0:  v = 32'sd210828714;
            5'd1:  v = 32'sd124459457;
            5'd2:  v = 32'sd65760959;
            5'd3:  v = 32'sd33381290;
            5'd4:  v = 32'sd16755422;
            5'd5:  v = 32'sd8385879;
            5'd6:  v = 32'sd4193963;
            5'd7:  v = 32'sd2097109;
            5'd8:  v = 32'sd1048571;
            5'd9:  v = 32'sd524287;
            5'd10: v = 32'sd262144;
            5'd11: v = 32'sd131072;
            5'd12: v = 32'sd65536;
            5'd13: v = 32'sd32768;
            5'd14: v = 32'sd16384;
            5'd15: v = 32'sd8192;
            5'd16: v = 32'sd4096;
            5'd17: v = 32'sd2048;
            5'd18: v = 32'sd1024;
            5'd19: v = 32'sd512;
            5'd20: v = 32'sd256;
            5'd21: v = 32'sd128;
            5'd22: v = 32'sd64;
            5'd23: v = 32'sd32;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/rana_front.sv
// Front end: tracks genome position and builds jobs for the back end.
module rana_front
#(
    parameter int MAX_GENES = rana_pkg::MAX_GENES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [rana_pkg::GENE_W-1:0] gene,
    input  logic                              last,
    input  logic                              in_valid,
    output logic                              in_ready,
    output rana_pkg::rana_job_t               job,
    output logic                              job_valid,
    input  logic                              job_ready
);
    import rana_pkg::*;

    logic signed [GENE_W-1:0] prev_reg;
    logic [10:0]              count_reg;
    logic                     ovf_reg;
    logic                     take;
    logic                     is_first;
    logic                     accept_gene;

    assign in_ready    = job_ready;
    assign take        = in_valid && job_ready;
    assign is_first    = (count_reg == 11'd0);
    assign accept_gene = !is_first && (count_reg < 11'(MAX_GENES));

    // Job built from current state and incoming gene
    always_comb
    begin
        job = '0;
        job.finish = last;
        if (is_first)
        begin
            job.x        = gene;
            job.y        = gene;
            job.do_term  = 1'b0;
            job.count    = 11'd1;
            job.overflow = ovf_reg;
        end
        else if (accept_gene)
        begin
            job.x        = prev_reg;
            job.y        = gene;
            job.do_term  = 1'b1;
            job.count    = count_reg + 11'd1;
            job.overflow = ovf_reg;
        end
        else
        begin
            job.x        = prev_reg;
            job.y        = prev_reg;
            job.do_term  = 1'b0;
            job.count    = count_reg;
            job.overflow = 1'b1;
        end
    end

    // A job is sent only if it carries a term or ends the genome
    assign job_valid = in_valid && (job.do_term || last);

    // Genome position; the back end keeps the first gene from the first job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            prev_reg  <= '0;
        end
        else if (take)
        begin
            if (last)
            begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= job.count;
                ovf_reg   <= job.overflow;
                if (is_first || accept_gene)
                    prev_reg <= gene;
            end
        end
    end

endmodule

FILE: hdl/rana_queue.sv
// Small FIFO between front and back ends.
module rana_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rana_pkg::rana_job_t wr_data,
    input  logic                wr_valid,
    output logic                wr_ready,
    output rana_pkg::rana_job_t rd_data,
    output logic                rd_valid,
    input  logic                rd_ready
);
    import rana_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    rana_job_t       mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg;
    logic [AW-1:0]   rp_reg;
    logic [AW:0]     cnt_reg;
    logic            wr_en;
    logic            rd_en;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule

FILE: hdl/rana_back.sv
// Back end: computes Rana terms with shared sqrt / CORDIC / multiply,
// accumulates, and divides on genome end.
module rana_back
#(
    parameter int CORDIC_STEPS = rana_pkg::CORDIC_STEPS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rana_pkg::rana_job_t               job,
    input  logic                              job_valid,
    output logic                              job_ready,
    output logic signed [rana_pkg::FIT_W-1:0] fitness,
    output logic                              overflow,
    output logic                              out_valid,
    input  logic                              out_ready
);
    import rana_pkg::*;

    localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    rana_state_t state_reg, state_next;

    rana_job_t                job_reg;
    logic signed [GENE_W-1:0] first_reg;
    logic                     have_first_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic                     wrap_reg;    // working on the wrap term
    logic                     pass_reg;    // 0: first argument, 1: second
    logic [ARG_W-1:0]         a2_reg;
    // sqrt
    logic [RAD_W-1:0]         rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [4:0]               sq_i_reg;
    // angle / cordic
    logic signed [ANG_W+2:0]  ang_reg;
    logic                     neg_reg;
    logic signed [CORD_W-1:0] cx_reg, cy_reg;
    logic [4:0]               k_reg;
    logic signed [CORD_W-1:0] s1_reg, c1_reg, s2_reg, c2_reg;
    // products
    logic signed [CORD_W-1:0] p1_reg, p2_reg;
    logic signed [59:0]       mix_reg;
    // division
    logic [SUM_W-1:0]         dq_reg;
    logic [SUM_W-1:0]         drem_reg;
    logic [5:0]               d_i_reg;
    logic                     dneg_reg;
    // output
    logic signed [FIT_W-1:0]  fit_reg;
    logic                     ovf_out_reg;
    logic                     out_valid_reg;

    assign fitness   = fit_reg;
    assign overflow  = ovf_out_reg;
    assign out_valid = out_valid_reg;
    assign job_ready = (state_reg == ST_IDLE) && !out_valid_reg;

    // Operand selection for the current term
    logic signed [GENE_W-1:0] tx, ty;
    logic signed [GENE_W+1:0] d1, d2;
    always_comb
    begin
        tx = wrap_reg ? job_reg.y : job_reg.x;
        ty = wrap_reg ? first_reg : job_reg.y;
        d1 = 26'(ty) + ONE_Q14 - 26'(tx);
        d2 = 26'(tx) + 26'(ty) + ONE_Q14;
    end

    // Sqrt step: one result bit per cycle, restoring
    logic [RAD_W-1:0] trial;
    logic [ROOT_W+1:0] trial_root;
    always_comb
    begin
        trial_root = {root_reg, 2'b01};
        trial = rem_reg;
    end

    // CORDIC step
    logic signed [CORD_W-1:0] dx, dy;
    logic signed [ANG_W-1:0]  at;
    always_comb
    begin
        dx = cy_reg >>> k_reg;
        dy = cx_reg >>> k_reg;
        at = atan_lut(k_reg);
    end

    // Angle reduction: root<<14 mod 2pi by repeated compare/subtract
    logic signed [ANG_W+2:0] root_ang;
    assign root_ang = 35'({root_reg, 14'd0});

    // Division step
    logic [SUM_W:0] dsub;
    logic [SUM_W-1:0] dshift;
    assign dshift = {drem_reg[SUM_W-2:0], dq_reg[SUM_W-1]};
    assign dsub   = {1'b0, dshift} - {26'd0, job_reg.count};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (job_valid && job_ready) state_next = ST_ARG;
            ST_ARG:    state_next = ST_SQRT;
            ST_SQRT:   if (sq_i_reg == 5'd0) state_next = ST_RED;
            ST_RED:    if (ang_reg < TWO_PI_Q28) state_next = ST_FOLD;
            ST_FOLD:   state_next = ST_CORDIC;
            ST_CORDIC:
                if (k_reg == 5'(STEPS-1))
                    state_next = pass_reg ? ST_MUL1 : ST_SQRT;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_ACC;
            ST_ACC:
            begin
                // term of a finishing job is followed by the wrap term
                priority if (!wrap_reg && job_reg.finish)
                    state_next = ST_ARG;
                else if (!job_reg.finish)
                    state_next = ST_IDLE;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:    if (d_i_reg == 6'd0) state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            sum_reg        <= '0;
            have_first_reg <= 1'b0;
            wrap_reg       <= 1'b0;
            pass_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid && job_ready)
                    begin
                        job_reg  <= job;
                        wrap_reg <= !job.do_term;
                        if (!have_first_reg)
                        begin
                            first_reg      <= job.x;
                            have_first_reg <= 1'b1;
                        end
                    end
                end
                ST_ARG:
                begin
                    a2_reg   <= d2[GENE_W+1] ? ARG_W'(-d2) : ARG_W'(d2);
                    rem_reg  <= {(d1[GENE_W+1] ? ARG_W'(-d1) : ARG_W'(d1)), 14'd0};
                    root_reg <= '0;
                    sq_i_reg <= 5'(ROOT_W-1);
                    pass_reg <= 1'b0;
                end
                ST_SQRT:
                begin
                    // compare rem top bits against (root<<2|1) at bit position
                    if ((trial >> (2*sq_i_reg)) >= RAD_W'(trial_root))
                    begin
                        rem_reg  <= trial - (RAD_W'(trial_root) << (2*sq_i_reg));
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    end
                    else
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    if (sq_i_reg != 5'd0)
                        sq_i_reg <= sq_i_reg - 5'd1;
                    else
                        ang_reg <= 35'({{root_reg[ROOT_W-2:0],
                            ((trial >> 0) >= RAD_W'(trial_root))}, 14'd0});
                end
                ST_RED:
                begin
                    if (ang_reg >= TWO_PI_Q28)
                        ang_reg <= ang_reg - TWO_PI_Q28;
                end
                ST_FOLD:
                begin
                    logic signed [ANG_W+2:0] r;
                    r = (ang_reg > PI_Q28) ? ang_reg - TWO_PI_Q28 : ang_reg;
                    neg_reg <= 1'b0;
                    if (r > HALF_PI_Q28)
                    begin
                        r = r - PI_Q28;
                        neg_reg <= 1'b1;
                    end
                    else if (r < -HALF_PI_Q28)
                    begin
                        r = r + PI_Q28;
                        neg_reg <= 1'b1;
                    end
                    ang_reg <= r;
                    cx_reg  <= CORDIC_K_Q28;
                    cy_reg  <= '0;
                    k_reg   <= '0;
                end
                ST_CORDIC:
                begin
                    logic signed [CORD_W-1:0] nx, ny;
                    if (!ang_reg[ANG_W+2])
                    begin
                        nx = cx_reg - dx;
                        ny = cy_reg + dy;
                        ang_reg <= ang_reg - 35'(at);
                    end
                    else
                    begin
                        nx = cx_reg + dx;
                        ny = cy_reg - dy;
                        ang_reg <= ang_reg + 35'(at);
                    end
                    cx_reg <= nx;
                    cy_reg <= ny;
                    k_reg  <= k_reg + 5'd1;
                    if (k_reg == 5'(STEPS-1))
                    begin
                        if (!pass_reg)
                        begin
                            s1_reg   <= neg_reg ? -ny : ny;
                            c1_reg   <= neg_reg ? -nx : nx;
                            pass_reg <= 1'b1;
                            rem_reg  <= {a2_reg, 14'd0};
                            root_reg <= '0;
                            sq_i_reg <= 5'(ROOT_W-1);
                        end
                        else
                        begin
                            s2_reg <= neg_reg ? -ny : ny;
                            c2_reg <= neg_reg ? -nx : nx;
                        end
                    end
                end
                ST_MUL1:
                begin
                    p1_reg <= CORD_W'((64'(s1_reg) * 64'(c2_reg)) >>> 28);
                    p2_reg <= CORD_W'((64'(c1_reg) * 64'(s2_reg)) >>> 28);
                end
                ST_MUL2:
                begin
                    mix_reg <= 60'(tx) * 60'(p1_reg)
                             + 60'(26'(ty) + ONE_Q14) * 60'(p2_reg);
                end
                ST_ACC:
                begin
                    logic signed [SUM_W-1:0] ns;
                    ns = sum_reg + SUM_W'(mix_reg >>> 28);
                    sum_reg <= ns;
                    if (!wrap_reg && job_reg.finish)
                        wrap_reg <= 1'b1;
                    else if (job_reg.finish)
                    begin
                        dneg_reg <= ns[SUM_W-1];
                        dq_reg   <= ns[SUM_W-1] ? -ns : ns;
                        drem_reg <= '0;
                        d_i_reg  <= 6'(SUM_W-1);
                    end
                end
                ST_DIV:
                begin
                    if (!dsub[SUM_W])
                    begin
                        drem_reg <= dsub[SUM_W-1:0];
                        dq_reg   <= {dq_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dshift;
                        dq_reg   <= {dq_reg[SUM_W-2:0], 1'b0};
                    end
                    if (d_i_reg != 6'd0)
                        d_i_reg <= d_i_reg - 6'd1;
                end
                ST_OUT:
                begin
                    logic signed [SUM_W-1:0] m;
                    m = dneg_reg ? -$signed(dq_reg) : $signed(dq_reg);
                    if (m > FIT_MAX)
                        fit_reg <= FIT_W'(FIT_MAX);
                    else if (m < FIT_MIN)
                        fit_reg <= FIT_W'(FIT_MIN);
                    else
                        fit_reg <= FIT_W'(m);
                    ovf_out_reg    <= job_reg.overflow;
                    out_valid_reg  <= 1'b1;
                    sum_reg        <= '0;
                    have_first_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: hdl/rana_fitness_evaluator_top.sv
// Rana fitness evaluator.
// Input stream (s_axis): one gene per transaction, tdata[23:0] = signed Q10.14
// gene, tlast marks the final gene of a genome. Output stream (m_axis): one
// transaction per genome, tdata[24:0] = mean fitness (signed Q11.14),
// tuser = overflow (genes beyond MAX_GENES were dropped).
// A front end tracks genome position and forms term jobs; a two-entry queue
// decouples it from the back end, which runs one job at a time.
// Each term runs the shared bit-serial square root, the angle reduction and
// the CORDIC unit once for each of its two arguments, then multiplies and
// accumulates; the square root and CORDIC dominate. The last gene adds the
// wrap term and a bit-serial divide. Genes that add no term (first gene,
// dropped genes) send no job to the back end unless they end the genome.
// Reset clears all genome state; the output register holds a result until
// m_axis_tready; while it waits the back end takes no new job and the queue
// fills, then s_axis_tready drops.
module rana_fitness_evaluator_top
#(
    parameter int MAX_GENES    = rana_pkg::MAX_GENES_DEF,
    parameter int CORDIC_STEPS = rana_pkg::CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,    // [23:0] gene
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [24:0] fitness, rest zero
    output logic        m_axis_tuser     // [0] overflow
);
    import rana_pkg::*;

    rana_job_t job_f, job_b;
    logic      jf_valid, jf_ready, jb_valid, jb_ready;
    logic signed [FIT_W-1:0] fit;

    rana_front #(.MAX_GENES(MAX_GENES)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .gene      (s_axis_tdata),
        .last      (s_axis_tlast),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .job       (job_f),
        .job_valid (jf_valid),
        .job_ready (jf_ready)
    );

    rana_queue #(.DEPTH(2)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (job_f),
        .wr_valid (jf_valid),
        .wr_ready (jf_ready),
        .rd_data  (job_b),
        .rd_valid (jb_valid),
        .rd_ready (jb_ready)
    );

    rana_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job_b),
        .job_valid (jb_valid),
        .job_ready (jb_ready),
        .fitness   (fit),
        .overflow  (m_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, fit};

endmodule
